@@ hw/rtl/sfpi_pkg.sv @@
// ----------------------------------------------------------------------------
// sfpi_pkg
// Shared types and constants of the speed fusion PI controller.
// ----------------------------------------------------------------------------
package sfpi_pkg;

	localparam int unsigned CountW  = 16;
	localparam int unsigned TachW   = 15;
	localparam int unsigned SpeedW  = 16;
	localparam int unsigned ScaleW  = 32;
	localparam int unsigned GainW   = 18;
	localparam int unsigned LimitW  = 15;
	localparam int unsigned AccW    = 38;
	localparam int unsigned RawW    = AccW - 16;
	localparam int unsigned CfgIdxW = 3;
	localparam int unsigned CfgDatW = 32;
	localparam int unsigned InDatW  = 48;
	localparam int unsigned OutDatW = 40;

	typedef enum logic [CfgIdxW-1:0] {
		REG_RPM_PER_TICK   = 3'd0,
		REG_FUSE_THRESHOLD = 3'd1,
		REG_GAIN_NOW       = 3'd2,
		REG_GAIN_PREV      = 3'd3,
		REG_DRIVE_LIMIT    = 3'd4
	} cfg_reg_t;

	localparam logic [ScaleW-1:0] RpmPerTickRst   = 32'd65536;
	localparam logic [TachW-1:0]  FuseThresholdRst = 15'd150;
	localparam logic [GainW-1:0]  GainNowRst      = 18'd112059;
	localparam logic [GainW-1:0]  GainPrevRst     = 18'd109818;
	localparam logic [LimitW-1:0] DriveLimitRst   = 15'd25000;

	typedef struct packed {
		logic load_in;
		logic do_enc;
		logic do_fuse;
		logic do_prod0;
		logic do_prod1;
		logic do_out;
	} sfpi_cmd_t;

endpackage

@@ hw/rtl/sfpi_datapath.sv @@
// ----------------------------------------------------------------------------
// sfpi_datapath
// Registers, speed fusion and velocity-form PI arithmetic, driven by commands.
// ----------------------------------------------------------------------------
module sfpi_datapath
	import sfpi_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  sfpi_cmd_t            cmd,
	input  logic                 cfg_we,
	input  logic [CfgIdxW-1:0]   cfg_index,
	input  logic [CfgDatW-1:0]   cfg_data,
	input  logic [InDatW-1:0]    in_data,
	output logic [OutDatW-1:0]   out_data
);

	logic [ScaleW-1:0]        rpm_per_tick_q;
	logic [TachW-1:0]         fuse_threshold_q;
	logic [GainW-1:0]         gain_now_q;
	logic [GainW-1:0]         gain_prev_q;
	logic [LimitW-1:0]        drive_limit_q;

	logic [CountW-1:0]        count_q;
	logic [TachW-1:0]         tachy_q;
	logic                     reverse_q;
	logic signed [SpeedW-1:0] setpoint_q;

	logic signed [SpeedW-1:0] enc_q;
	logic signed [SpeedW-1:0] speed_q;
	logic signed [SpeedW-1:0] err_q;
	logic signed [AccW-1:0]   acc_q;
	logic signed [SpeedW-1:0] last_err_q;
	logic signed [SpeedW-1:0] last_drive_q;

	logic signed [SpeedW-1:0] drive_q;
	logic signed [SpeedW-1:0] meas_q;
	logic                     sat_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rpm_per_tick_q   <= RpmPerTickRst;
			fuse_threshold_q <= FuseThresholdRst;
			gain_now_q       <= GainNowRst;
			gain_prev_q      <= GainPrevRst;
			drive_limit_q    <= DriveLimitRst;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_RPM_PER_TICK:   rpm_per_tick_q   <= cfg_data;
				REG_FUSE_THRESHOLD: fuse_threshold_q <= cfg_data[TachW-1:0];
				REG_GAIN_NOW:       gain_now_q       <= cfg_data[GainW-1:0];
				REG_GAIN_PREV:      gain_prev_q      <= cfg_data[GainW-1:0];
				REG_DRIVE_LIMIT:    drive_limit_q    <= cfg_data[LimitW-1:0];
				default: ;
			endcase
		end
	end

	logic [CountW+ScaleW-1:0] enc_prod;
	assign enc_prod = count_q * rpm_per_tick_q;

	logic signed [SpeedW-1:0] tach;
	logic signed [SpeedW:0]   fuse_sum;
	logic signed [SpeedW:0]   fuse_half;
	logic signed [SpeedW-1:0] speed;
	assign tach      = reverse_q ? -$signed({1'b0, tachy_q}) : $signed({1'b0, tachy_q});
	assign fuse_sum  = {enc_q[SpeedW-1], enc_q} + {tach[SpeedW-1], tach};
	assign fuse_half = (fuse_sum + {{SpeedW{1'b0}}, fuse_sum[SpeedW]}) >>> 1;
	assign speed     = (tachy_q > fuse_threshold_q) ? fuse_half[SpeedW-1:0] : enc_q;

	logic signed [AccW-1:0] prod_now;
	logic signed [AccW-1:0] prod_prev;
	assign prod_now  = AccW'($signed({1'b0, gain_now_q}) * err_q);
	assign prod_prev = AccW'($signed({1'b0, gain_prev_q}) * last_err_q);

	logic signed [RawW-1:0] raw;
	logic signed [RawW-1:0] lim;
	logic                   over_hi;
	logic                   over_lo;
	assign raw     = acc_q[AccW-1:16] + {{(RawW-1){1'b0}}, acc_q[AccW-1] & (|acc_q[15:0])};
	assign lim     = $signed({{(RawW-LimitW){1'b0}}, drive_limit_q});
	assign over_hi = raw > lim;
	assign over_lo = raw < -lim;

	logic signed [SpeedW-1:0] drive_next;
	always_comb begin
		drive_next = raw[SpeedW-1:0];
		if (over_hi) drive_next = lim[SpeedW-1:0];
		if (over_lo) drive_next = -lim[SpeedW-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			count_q    <= in_data[15:0];
			tachy_q    <= in_data[30:16];
			reverse_q  <= in_data[31];
			setpoint_q <= in_data[47:32];
		end
		if (cmd.do_enc)   enc_q <= enc_prod[31:16];
		if (cmd.do_fuse) begin
			speed_q <= speed;
			err_q   <= setpoint_q - speed;
		end
		if (cmd.do_prod0) acc_q <= prod_now + {{(AccW-SpeedW-16){last_drive_q[SpeedW-1]}},
			last_drive_q, 16'd0};
		if (cmd.do_prod1) acc_q <= acc_q - prod_prev;
		if (cmd.do_out) begin
			drive_q <= drive_next;
			meas_q  <= speed_q;
			sat_q   <= over_hi | over_lo;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_err_q   <= '0;
			last_drive_q <= '0;
		end else if (cmd.do_out) begin
			last_err_q   <= err_q;
			last_drive_q <= drive_next;
		end
	end

	assign out_data = {7'd0, sat_q, meas_q, drive_q};

endmodule

@@ hw/rtl/sfpi_controller.sv @@
// ----------------------------------------------------------------------------
// sfpi_controller
// Sequencer of one control tick and output handshake.
// ----------------------------------------------------------------------------
module sfpi_controller
	import sfpi_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output sfpi_cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_ENC   = 6'b000010,
		ST_FUSE  = 6'b000100,
		ST_PROD0 = 6'b001000,
		ST_PROD1 = 6'b010000,
		ST_CLAMP = 6'b100000
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.load_in = in_valid;
				if (in_valid) state_d = ST_ENC;
			end
			ST_ENC: begin
				cmd.do_enc = 1'b1;
				state_d    = ST_FUSE;
			end
			ST_FUSE: begin
				cmd.do_fuse = 1'b1;
				state_d     = ST_PROD0;
			end
			ST_PROD0: begin
				cmd.do_prod0 = 1'b1;
				state_d      = ST_PROD1;
			end
			ST_PROD1: begin
				cmd.do_prod1 = 1'b1;
				state_d      = ST_CLAMP;
			end
			ST_CLAMP: begin
				cmd.do_out = out_free;
				if (out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.do_out)     out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	a_cmd_onehot0: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_out_from_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_CLAMP))
		else $error("result raised outside the clamp step");

	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !cmd.do_out && !$rose(out_valid_q))
		else $error("result loaded right after an accepted item");

endmodule

@@ hw/rtl/speed_fusion_pi_controller_top.sv @@
// ----------------------------------------------------------------------------
// speed_fusion_pi_controller_top
// Encoder/tachometer speed fusion followed by a saturating velocity-form PI.
//
//   channel  | direction | handshake             | payload
//   s_axis   | in        | s_tvalid / s_tready   | s_tdata  (48 bit)
//   m_axis   | out       | m_tvalid / m_tready   | m_tdata  (40 bit)
//   cfg      | in        | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each item passes six steps: accept, encoder multiply, fusion, two gain
// multiply-accumulate steps on a single multiplier each, and clamp.
// The result register frees the pipeline once loaded; a stalled m_tready holds
// the clamp step until the previous result is taken. cfg_ready is always high.
// Reset restores the register defaults and clears the controller history.
// ----------------------------------------------------------------------------
module speed_fusion_pi_controller_top
	import sfpi_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// encoder_count[15:0], tachy_rpm[30:16], reverse[31], setpoint[47:32]
	input  logic [InDatW-1:0]  s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	// drive[15:0], measured_speed[31:16], saturated[32], zero[39:33]
	output logic [OutDatW-1:0] m_tdata,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [CfgDatW-1:0] cfg_data
);

	sfpi_cmd_t cmd;

	assign cfg_ready = 1'b1;

	sfpi_controller u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd)
	);

	sfpi_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (s_tdata),
		.out_data  (m_tdata)
	);

endmodule

@@ tb/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the speed fusion PI controller. Control ticks go in
// on the slave stream and are predicted in order against a local copy of the
// fusion and PI arithmetic and its history. Each drive result is checked field
// by field. Directed ticks cover field extremes, the fusion threshold, wrap of
// encoder speed and error, a zero drive limit and extreme gains. Random
// phases follow with changing register settings and stream back-pressure.
// ----------------------------------------------------------------------------
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import sfpi_pkg::*;

	localparam int                 DrainCycles    = 16;
	localparam int                 RandPhases     = 8;
	localparam int                 ItemsPerPhase  = 144;
	localparam logic [CfgIdxW-1:0] RegUnusedFirst = 3'd5;
	localparam logic [CfgIdxW-1:0] RegUnusedLast  = 3'd7;

	typedef struct packed {
		logic signed [15:0] drive;
		logic signed [15:0] speed;
		logic               sat;
	} tick_result_t;

	logic               clk;
	logic               arst_n;
	logic               s_tvalid;
	logic               s_tready;
	logic [InDatW-1:0]  s_tdata;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [OutDatW-1:0] m_tdata;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index;
	logic [CfgDatW-1:0] cfg_data;

	logic [ScaleW-1:0]  rpm_scale;
	logic [TachW-1:0]   fuse_thr;
	logic [GainW-1:0]   gain_cur;
	logic [GainW-1:0]   gain_old;
	logic [LimitW-1:0]  drive_lim;
	logic signed [15:0] hist_error;
	logic signed [15:0] hist_drive;

	tick_result_t expected_ticks[$];
	int           mismatch_count = 0;
	int           result_index   = 0;
	int           send_idle_pct  = 0;
	int           recv_stall_pct = 0;

	speed_fusion_pi_controller_top DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	function automatic tick_result_t predict_tick(input logic [15:0] count,
			input logic [14:0] tach_mag, input logic rev, input logic signed [15:0] sp);
		logic [47:0]        prod;
		logic signed [15:0] enc;
		logic signed [15:0] err;
		int                 tach;
		int                 thr;
		int                 spd;
		longint             acc;
		longint             raw;
		longint             lim;
		tick_result_t       r;
		prod = 48'(count) * 48'(rpm_scale);
		enc  = prod[31:16];
		tach = rev ? -int'(tach_mag) : int'(tach_mag);
		thr  = int'(fuse_thr);
		if (tach > thr || tach < -thr)
			spd = (int'(enc) + tach) / 2;
		else
			spd = int'(enc);
		err = 16'(int'(sp) - spd);
		acc = longint'(gain_cur) * longint'(err) - longint'(gain_old) * longint'(hist_error)
			+ longint'(hist_drive) * 65536;
		raw   = acc / 65536;
		lim   = longint'(drive_lim);
		r.sat = 1'b0;
		if (raw > lim) begin
			raw   = lim;
			r.sat = 1'b1;
		end
		if (raw < -lim) begin
			raw   = -lim;
			r.sat = 1'b1;
		end
		r.drive    = raw[15:0];
		r.speed    = spd[15:0];
		hist_error = err;
		hist_drive = raw[15:0];
		return r;
	endfunction

	function automatic void apply_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
		case (idx)
			REG_RPM_PER_TICK:   rpm_scale = data;
			REG_FUSE_THRESHOLD: fuse_thr  = data[TachW-1:0];
			REG_GAIN_NOW:       gain_cur  = data[GainW-1:0];
			REG_GAIN_PREV:      gain_old  = data[GainW-1:0];
			REG_DRIVE_LIMIT:    drive_lim = data[LimitW-1:0];
			default: ;
		endcase
	endfunction

	task automatic report_mismatch(input string what, input logic [39:0] got,
			input logic [39:0] want);
		$display("%0t ns result %0d: %s got %0h expected %0h",
			$time, result_index, what, got, want);
		mismatch_count++;
	endtask

	always @(posedge clk) begin : check_results
		tick_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_ticks.size() == 0) begin
				report_mismatch("unexpected item", m_tdata, '0);
			end else begin
				want = expected_ticks.pop_front();
				if (m_tdata[15:0] !== want.drive)
					report_mismatch("drive", m_tdata[15:0], want.drive);
				if (m_tdata[31:16] !== want.speed)
					report_mismatch("measured_speed", m_tdata[31:16], want.speed);
				if (m_tdata[32] !== want.sat)
					report_mismatch("saturated", m_tdata[32], want.sat);
				if (m_tdata[39:33] !== '0)
					report_mismatch("padding", m_tdata[39:33], '0);
			end
			result_index++;
		end
	end

	task automatic send_tick(input logic [15:0] count, input logic [14:0] tach,
			input logic rev, input logic [15:0] sp);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tdata  <= {sp, rev, tach, count};
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		expected_ticks.push_back(predict_tick(count, tach, rev, sp));
	endtask

	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_ticks.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [31:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		apply_reg(idx, data);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_all(input logic [31:0] rpt, input logic [31:0] thr,
			input logic [31:0] g0, input logic [31:0] g1, input logic [31:0] lim);
		drain_results();
		write_reg(REG_RPM_PER_TICK, rpt);
		write_reg(REG_FUSE_THRESHOLD, thr);
		write_reg(REG_GAIN_NOW, g0);
		write_reg(REG_GAIN_PREV, g1);
		write_reg(REG_DRIVE_LIMIT, lim);
	endtask

	task automatic test_field_extremes();
		send_tick(16'h0000, 15'h0000, 1'b0, 16'h0000);
		send_tick(16'hFFFF, 15'h7FFF, 1'b0, 16'h7FFF);
		send_tick(16'hFFFF, 15'h7FFF, 1'b1, 16'h8000);
		send_tick(16'h1234, 15'h0000, 1'b1, 16'h0000);
	endtask

	task automatic test_fusion_threshold();
		send_tick(16'd100, 15'd150, 1'b1, -16'sd100);
		send_tick(16'd100, 15'd151, 1'b1, -16'sd100);
		send_tick(16'd200, 15'd150, 1'b0, 16'sd300);
		send_tick(16'd200, 15'd151, 1'b0, 16'sd300);
	endtask

	task automatic test_wrap_cases();
		send_tick(16'h8000, 15'd0, 1'b0, 16'h7FFF);
		send_tick(16'h7FFF, 15'd0, 1'b0, 16'h8000);
		set_all(32'hFFFF_FFFF, FuseThresholdRst, GainNowRst, GainPrevRst, DriveLimitRst);
		send_tick(16'hFFFF, 15'd0, 1'b0, 16'h0000);
		send_tick(16'h0101, 15'd0, 1'b0, 16'h0000);
		set_all(32'h0, FuseThresholdRst, GainNowRst, GainPrevRst, DriveLimitRst);
		send_tick(16'hFFFF, 15'd20000, 1'b1, 16'sd1234);
	endtask

	task automatic test_zero_limit();
		set_all(RpmPerTickRst, FuseThresholdRst, GainNowRst, GainPrevRst, 32'h0);
		send_tick(16'd0, 15'd0, 1'b0, 16'h7FFF);
		send_tick(16'd0, 15'd0, 1'b0, 16'h0000);
		send_tick(16'd1000, 15'd0, 1'b0, 16'sd1000);
	endtask

	task automatic test_gain_extremes();
		set_all(RpmPerTickRst, 32'h7FFF, 32'h3FFFF, 32'h3FFFF, 32'h7FFF);
		send_tick(16'd0, 15'h7FFF, 1'b0, 16'h7FFF);
		send_tick(16'd0, 15'h7FFF, 1'b1, 16'h8000);
		send_tick(16'd0, 15'd0, 1'b0, 16'h8000);
		send_tick(16'd0, 15'd0, 1'b0, 16'h7FFF);
		set_all(RpmPerTickRst, 32'h0, 32'h0, 32'h0, 32'h7FFF);
		send_tick(16'd10, 15'd1, 1'b0, 16'h0000);
		send_tick(16'd10, 15'd0, 1'b1, 16'h0000);
	endtask

	task automatic test_unused_index();
		drain_results();
		for (logic [CfgIdxW:0] i = RegUnusedFirst; i <= RegUnusedLast; i++)
			write_reg(i[CfgIdxW-1:0], $urandom);
		write_reg(REG_DRIVE_LIMIT, 32'hFFFF_8000 | 32'd500);
		send_tick(16'd3000, 15'd0, 1'b0, -16'sd3000);
		send_tick(16'd3000, 15'd2000, 1'b1, 16'sd3000);
	endtask

	task automatic randomise_settings();
		logic [31:0] rpt;
		logic [31:0] thr;
		logic [31:0] g0;
		logic [31:0] g1;
		logic [31:0] lim;
		case ($urandom_range(3))
			0:       rpt = RpmPerTickRst;
			1:       rpt = $urandom;
			2:       rpt = $urandom_range(32'h0010_0000, 32'h0000_1000);
			default: rpt = $urandom_range(1) ? 32'hFFFF_FFFF : 32'h0;
		endcase
		case ($urandom_range(2))
			0:       thr = $urandom;
			1:       thr = $urandom_range(400);
			default: thr = $urandom_range(1) ? 32'h7FFF : 32'h0;
		endcase
		g0  = $urandom_range(1) ? $urandom : GainNowRst + $urandom_range(2000) - 1000;
		g1  = $urandom_range(1) ? $urandom : GainPrevRst + $urandom_range(2000) - 1000;
		case ($urandom_range(3))
			0:       lim = $urandom;
			1:       lim = $urandom_range(2000);
			2:       lim = 32'h7FFF;
			default: lim = DriveLimitRst;
		endcase
		set_all(rpt, thr, g0, g1, lim);
	endtask

	task automatic send_random_tick();
		logic [15:0] count;
		logic [14:0] tach;
		logic        rev;
		logic [15:0] sp;
		int          t;
		case ($urandom_range(2))
			0:       count = $urandom_range(16'hFFFF);
			1:       count = $urandom_range(300);
			default: count = $urandom_range(5000, 300);
		endcase
		case ($urandom_range(2))
			0: tach = $urandom_range(15'h7FFF);
			1: begin
				t = int'(fuse_thr) + $urandom_range(4) - 2;
				if (t < 0)
					t = 0;
				if (t > 32767)
					t = 32767;
				tach = t[14:0];
			end
			default: tach = $urandom_range(400);
		endcase
		rev = $urandom_range(1);
		if ($urandom_range(1))
			sp = $urandom_range(16'hFFFF);
		else
			sp = 16'($urandom_range(6000) - 3000);
		send_tick(count, tach, rev, sp);
	endtask

	task automatic test_random_phases();
		for (int ph = 0; ph < RandPhases; ph++) begin
			if (ph == 0)
				set_all(RpmPerTickRst, FuseThresholdRst, GainNowRst, GainPrevRst,
					DriveLimitRst);
			else
				randomise_settings();
			case (ph % 4)
				0: begin
					send_idle_pct  = 0;
					recv_stall_pct = 0;
				end
				1: begin
					send_idle_pct  = 79;
					recv_stall_pct = 0;
				end
				2: begin
					send_idle_pct  = 0;
					recv_stall_pct = 79;
				end
				default: begin
					send_idle_pct  = 14;
					recv_stall_pct = 14;
				end
			endcase
			for (int n = 0; n < ItemsPerPhase; n++) begin
				if (n == ItemsPerPhase / 2)
					drain_results();
				send_random_tick();
			end
		end
	endtask

	initial begin
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		cfg_valid  = 1'b0;
		cfg_index  = '0;
		cfg_data   = '0;
		rpm_scale  = RpmPerTickRst;
		fuse_thr   = FuseThresholdRst;
		gain_cur   = GainNowRst;
		gain_old   = GainPrevRst;
		drive_lim  = DriveLimitRst;
		hist_error = '0;
		hist_drive = '0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		test_field_extremes();
		test_fusion_threshold();
		test_wrap_cases();
		test_zero_limit();
		test_gain_extremes();
		test_unused_index();
		test_random_phases();

		drain_results();
		if (mismatch_count == 0)
			$display("** speed_fusion_pi_controller_top: PASSED **");
		else
			$display("** speed_fusion_pi_controller_top: FAILED **");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("timeout with %0d results outstanding", expected_ticks.size());
		$display("** speed_fusion_pi_controller_top: FAILED **");
		$finish;
	end

endmodule

@@ files.f @@
hw/rtl/sfpi_pkg.sv
hw/rtl/sfpi_datapath.sv
hw/rtl/sfpi_controller.sv
hw/rtl/speed_fusion_pi_controller_top.sv
tb/tb_top.sv
